// ===== src/hsl_pkg.sv =====
`default_nettype none

package hsl_pkg;

  localparam int ChanW = 8;
  localparam int FracW = 16;
  localparam int HueW = 11;
  localparam int GainW = 12;

  // Divider geometry: quotient bits, numerator and divisor widths.
  localparam int DivQuoW = 16;
  localparam int DivNumW = 24;
  localparam int DivDenW = 8;
  localparam int DivBitsPerStage = 2;

  // Hue positions in 256ths of a sixth of a turn.
  localparam logic [HueW-1:0] HueSixth = 11'd256;
  localparam logic [HueW-1:0] HueThird = 11'd512;
  localparam logic [HueW-1:0] HueHalf = 11'd768;
  localparam logic [HueW-1:0] HueTwoThirds = 11'd1024;
  localparam logic [HueW-1:0] HueTurn = 11'd1536;

  localparam logic [GainW-1:0] GainUnity = 12'd256;

  // Register index, taken from paddr[2].
  localparam logic RegSatGain = 1'b0;
  localparam logic RegLumGain = 1'b1;

  typedef enum logic [1:0] {
    HUE_RED,
    HUE_GREEN,
    HUE_BLUE
  } hue_sel_t;

  typedef struct packed {
    logic [ChanW-1:0] alpha;
    hue_sel_t         sel;
    logic             neg;
    logic             grey;
    logic [FracW-1:0] lum;
  } pix_info_t;

  // floor(x / 65535) by reciprocal estimate and one correction step.
  function automatic logic [16:0] div_65535(input logic [31:0] x);
    logic [32:0] s;
    logic [16:0] q;
    logic [33:0] r;
    s = {1'b0, x} + {17'd0, x[31:16]};
    q = s[32:16];
    r = {2'b00, x} - ({1'b0, q, 16'd0} - {17'd0, q});
    if (r >= 34'd65535) begin
      q = q + 17'd1;
    end
    return q;
  endfunction

endpackage

`default_nettype wire

// ===== src/hsl_saturation_lightness_adjust.sv =====
// Saturation and lightness adjustment for a stream of ARGB8888 pixels.
// Each input transaction carries one pixel; each output transaction carries
// the adjusted pixel, with alpha copied through and red, green and blue
// rebuilt after the saturation and lightness gains have been applied.
// Both channels use valid and stall: a transaction completes on a clock edge
// where valid is high and stall is low.
// The pipeline takes one pixel per clock except while the output is stalled.
// Its depth is set by the two dividers that produce saturation and hue,
// which resolve DIV_STEP quotient bits per stage.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_stall is raised, so nothing is dropped or repeated.
// The gain registers are written over the APB-style port at byte address 0
// (saturation) and 4 (lightness) as unsigned Q4.8 values; reset sets both to
// 1.0 and empties the pipeline.
`default_nettype none

module hsl_saturation_lightness_adjust
  import hsl_pkg::*;
#(
  parameter int DIV_STEP = DivBitsPerStage
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [ChanW-1:0] alpha_in,
  input  wire logic [ChanW-1:0] red_in,
  input  wire logic [ChanW-1:0] green_in,
  input  wire logic [ChanW-1:0] blue_in,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic      [ChanW-1:0] alpha_out,
  output logic      [ChanW-1:0] red_out,
  output logic      [ChanW-1:0] green_out,
  output logic      [ChanW-1:0] blue_out,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [2:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output logic                  pready
);

  // Two analysis stages, the divider stages and five synthesis stages.
  localparam int DivStages = DivQuoW / DIV_STEP;
  localparam int Latency = 2 + DivStages + 5;

  // Gain registers. The user must change them only while the pipeline is empty; the block does not enforce it.
  logic [GainW-1:0] sat_gain, lum_gain;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sat_gain <= GainUnity;
      lum_gain <= GainUnity;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        RegSatGain: sat_gain <= pwdata[GainW-1:0];
        RegLumGain: lum_gain <= pwdata[GainW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegSatGain: prdata = {20'd0, sat_gain};
      RegLumGain: prdata = {20'd0, lum_gain};
      default: prdata = '0;
    endcase
  end

  // Pipeline control. Every stage advances together unless the result at
  // the output is being held back by the receiver; valid bits travel in
  // step with the data so that bubbles are carried through untouched.
  logic [Latency-1:0] vld;
  logic               en;

  assign en = !(vld[Latency-1] && out_stall);
  assign in_stall = !en;
  assign out_valid = vld[Latency-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Latency-2:0], in_valid};
    end
  end

  // Colour analysis: extremes, lightness and the divider operands.
  pix_info_t          info_a, info_d;
  logic [DivNumW-1:0] sat_num, hue_num;
  logic [DivDenW-1:0] sat_den, hue_den;
  logic [DivQuoW-1:0] sat_quo, hue_quo;
  logic [$bits(pix_info_t)-1:0] info_vec;

  hsl_analyse u_analyse (
    .clk     (clk),
    .en      (en),
    .alpha   (alpha_in),
    .red     (red_in),
    .green   (green_in),
    .blue    (blue_in),
    .info    (info_a),
    .sat_num (sat_num),
    .sat_den (sat_den),
    .hue_num (hue_num),
    .hue_den (hue_den)
  );

  // Saturation is d * 65535 / den and the hue fraction |diff| * 256 / d,
  // both rounded to nearest, resolved by matching pipelined dividers.
  hsl_div #(
    .NumW         (DivNumW),
    .DenW         (DivDenW),
    .QuoW         (DivQuoW),
    .BitsPerStage (DIV_STEP)
  ) u_sat_div (
    .clk (clk),
    .en  (en),
    .num (sat_num),
    .den (sat_den),
    .quo (sat_quo)
  );

  hsl_div #(
    .NumW         (DivNumW),
    .DenW         (DivDenW),
    .QuoW         (DivQuoW),
    .BitsPerStage (DIV_STEP)
  ) u_hue_div (
    .clk (clk),
    .en  (en),
    .num (hue_num),
    .den (hue_den),
    .quo (hue_quo)
  );

  // Alpha, lightness and the hue flags wait alongside the dividers.
  hsl_delay #(
    .Width ($bits(pix_info_t)),
    .Depth (DivStages)
  ) u_info_delay (
    .clk (clk),
    .en  (en),
    .d   (info_a),
    .q   (info_vec)
  );

  assign info_d = pix_info_t'(info_vec);

  // Gains, the two HSL levels, channel ramps and final byte rounding.
  hsl_synth u_synth (
    .clk       (clk),
    .en        (en),
    .sat_gain  (sat_gain),
    .lum_gain  (lum_gain),
    .info      (info_d),
    .sat_quo   (sat_quo),
    .hue_quo   (hue_quo),
    .alpha_out (alpha_out),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out)
  );

endmodule

`default_nettype wire

// ===== src/hsl_analyse.sv =====
`default_nettype none

module hsl_analyse
  import hsl_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic [ChanW-1:0]   alpha,
  input  wire logic [ChanW-1:0]   red,
  input  wire logic [ChanW-1:0]   green,
  input  wire logic [ChanW-1:0]   blue,
  output pix_info_t               info,
  output logic      [DivNumW-1:0] sat_num,
  output logic      [DivDenW-1:0] sat_den,
  output logic      [DivNumW-1:0] hue_num,
  output logic      [DivDenW-1:0] hue_den
);

  // First stage: extremes, dominant channel and hue difference.
  logic [ChanW-1:0] mx, mn, mag, alpha1;
  logic             neg;
  hue_sel_t         sel;

  logic [ChanW-1:0] mx_next, mn_next, mag_next;
  logic             neg_next;
  hue_sel_t         sel_next;
  logic [ChanW:0]   diff;

  always_comb begin
    mx_next = red;
    mn_next = red;
    if (green > mx_next) mx_next = green;
    if (blue > mx_next) mx_next = blue;
    if (green < mn_next) mn_next = green;
    if (blue < mn_next) mn_next = blue;
    if (mx_next == red) begin
      sel_next = HUE_RED;
      diff = {1'b0, green} - {1'b0, blue};
    end else if (mx_next == green) begin
      sel_next = HUE_GREEN;
      diff = {1'b0, blue} - {1'b0, red};
    end else begin
      sel_next = HUE_BLUE;
      diff = {1'b0, red} - {1'b0, green};
    end
    neg_next = diff[ChanW];
    mag_next = neg_next ? ChanW'(-diff) : diff[ChanW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx     <= mx_next;
      mn     <= mn_next;
      mag    <= mag_next;
      neg    <= neg_next;
      sel    <= sel_next;
      alpha1 <= alpha;
    end
  end

  // Second stage: lightness and the two divider operands.
  logic [ChanW-1:0] d;
  logic [ChanW:0]   sm;
  logic [ChanW-1:0] den;
  logic [17:0]      lum_x;

  always_comb begin
    d = mx - mn;
    sm = {1'b0, mx} + {1'b0, mn};
    if (sm < 9'd255) begin
      den = sm[ChanW-1:0];
    end else begin
      den = ChanW'(9'd510 - sm);
    end
    lum_x = ({1'b0, sm, 8'd0} + {9'd0, sm} + 18'd1) >> 1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      info.alpha <= alpha1;
      info.sel   <= sel;
      info.neg   <= neg;
      info.grey  <= (d == '0);
      info.lum   <= lum_x[FracW-1:0];
      sat_num    <= {d, 16'd0} - {16'd0, d} + {17'd0, den[ChanW-1:1]};
      sat_den    <= den;
      hue_num    <= {8'd0, mag, 8'd0} + {17'd0, d[ChanW-1:1]};
      hue_den    <= d;
    end
  end

endmodule

`default_nettype wire

// ===== src/hsl_div.sv =====
`default_nettype none

module hsl_div
  import hsl_pkg::*;
#(
  parameter int NumW = DivNumW,
  parameter int DenW = DivDenW,
  parameter int QuoW = DivQuoW,
  parameter int BitsPerStage = DivBitsPerStage
) (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire logic [NumW-1:0] num,
  input  wire logic [DenW-1:0] den,
  output logic      [QuoW-1:0] quo
);

  // Restoring division, a few quotient bits per register stage.
  // Requires num < den * 2**QuoW.
  localparam int Stages = QuoW / BitsPerStage;
  localparam int ShW = DenW + QuoW;
  localparam int CmpW = (ShW > NumW) ? ShW : NumW;

  logic [NumW-1:0] rem_q [Stages];
  logic [QuoW-1:0] quo_q [Stages];
  logic [DenW-1:0] den_q [Stages];

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    logic [NumW-1:0] rem_in, rem_o;
    logic [QuoW-1:0] quo_in, quo_o;
    logic [DenW-1:0] den_in;

    if (s == 0) begin : g_first
      assign rem_in = num;
      assign quo_in = '0;
      assign den_in = den;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign quo_in = quo_q[s-1];
      assign den_in = den_q[s-1];
    end

    always_comb begin
      int b;
      logic [CmpW-1:0] remx, sh;
      rem_o = rem_in;
      quo_o = quo_in;
      for (int k = 0; k < BitsPerStage; k++) begin
        b = QuoW - 1 - s * BitsPerStage - k;
        remx = CmpW'(rem_o);
        sh = CmpW'(den_in) << b;
        if (remx >= sh) begin
          rem_o = NumW'(remx - sh);
          quo_o[b] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s] <= rem_o;
        quo_q[s] <= quo_o;
        den_q[s] <= den_in;
      end
    end
  end

  assign quo = quo_q[Stages-1];

endmodule

`default_nettype wire

// ===== src/hsl_delay.sv =====
`default_nettype none

module hsl_delay #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [Width-1:0] d,
  output logic      [Width-1:0] q
);

  logic [Width-1:0] taps [Depth];

  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= d;
      for (int i = 1; i < Depth; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

  assign q = taps[Depth-1];

endmodule

`default_nettype wire

// ===== src/hsl_synth.sv =====
`default_nettype none

module hsl_synth
  import hsl_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic [GainW-1:0]   sat_gain,
  input  wire logic [GainW-1:0]   lum_gain,
  input  wire pix_info_t          info,
  input  wire logic [DivQuoW-1:0] sat_quo,
  input  wire logic [DivQuoW-1:0] hue_quo,
  output logic      [ChanW-1:0]   alpha_out,
  output logic      [ChanW-1:0]   red_out,
  output logic      [ChanW-1:0]   green_out,
  output logic      [ChanW-1:0]   blue_out
);

  // Gain stage: apply gains with saturation and assemble the hue.
  logic [FracW-1:0] g_sat, g_lum;
  logic [HueW-1:0]  g_hue;
  logic [ChanW-1:0] g_alpha;

  logic [FracW-1:0] sat_raw;
  logic [27:0]      sat_prod, lum_prod;
  logic [HueW-1:0]  hq, hue_next;

  always_comb begin
    sat_raw = info.grey ? '0 : sat_quo;
    sat_prod = {12'd0, sat_raw} * {16'd0, sat_gain} + 28'd128;
    lum_prod = {12'd0, info.lum} * {16'd0, lum_gain} + 28'd128;
    hq = {2'b00, hue_quo[8:0]};
    unique case (info.sel)
      HUE_RED: begin
        if (info.neg && hq != '0) hue_next = HueTurn - hq;
        else hue_next = hq;
      end
      HUE_GREEN: hue_next = info.neg ? HueThird - hq : HueThird + hq;
      HUE_BLUE: hue_next = info.neg ? HueTwoThirds - hq : HueTwoThirds + hq;
      default: hue_next = '0;
    endcase
    if (info.grey) hue_next = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_sat   <= (sat_prod[27:24] != '0) ? '1 : sat_prod[23:8];
      g_lum   <= (lum_prod[27:24] != '0) ? '1 : lum_prod[23:8];
      g_hue   <= hue_next;
      g_alpha <= info.alpha;
    end
  end

  // Product stage.
  logic [31:0]      p_raw;
  logic [FracW-1:0] p_sat, p_lum;
  logic [HueW-1:0]  p_hue;
  logic [ChanW-1:0] p_alpha;

  always_ff @(posedge clk) begin
    if (en) begin
      p_raw   <= g_lum * g_sat + 32'd32767;
      p_sat   <= g_sat;
      p_lum   <= g_lum;
      p_hue   <= g_hue;
      p_alpha <= g_alpha;
    end
  end

  // Levels stage: the two levels and the channel positions on the turn.
  logic [FracW-1:0] lv_p, lv_q;
  logic [HueW-1:0]  lv_t [3];
  logic [ChanW-1:0] lv_alpha;

  logic [16:0]      prod_full;
  logic [FracW-1:0] prod;
  logic [17:0]      q_x;
  logic [18:0]      p_x;
  logic [FracW-1:0] q_c, p_c;
  logic [HueW:0]    t_r, t_b;

  always_comb begin
    prod_full = div_65535(p_raw);
    prod = prod_full[FracW-1:0];
    if (p_lum <= 16'd32767) begin
      q_x = {2'b00, p_lum} + {2'b00, prod};
    end else begin
      q_x = {2'b00, p_lum} + {2'b00, p_sat} - {2'b00, prod};
    end
    q_c = (q_x > 18'd65535) ? '1 : q_x[FracW-1:0];
    p_x = {2'b00, p_lum, 1'b0} - {3'b000, q_c};
    if (p_x[18]) p_c = '0;
    else if (p_x[16:0] > {1'b0, q_c}) p_c = q_c;
    else p_c = p_x[FracW-1:0];
    t_r = {1'b0, p_hue} + {1'b0, HueThird};
    if (t_r >= {1'b0, HueTurn}) t_r = t_r - {1'b0, HueTurn};
    t_b = {1'b0, p_hue} + {1'b0, HueTwoThirds};
    if (t_b >= {1'b0, HueTurn}) t_b = t_b - {1'b0, HueTurn};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lv_p     <= p_c;
      lv_q     <= q_c;
      lv_t[0]  <= t_r[HueW-1:0];
      lv_t[1]  <= p_hue;
      lv_t[2]  <= t_b[HueW-1:0];
      lv_alpha <= p_alpha;
    end
  end

  // Channel stage: one ramp multiplier per colour lane.
  logic [FracW-1:0] ch_v [3];
  logic [ChanW-1:0] ch_alpha;

  logic [FracW-1:0] span;
  logic [8:0]       w    [3];
  logic [24:0]      m    [3];
  logic [FracW-1:0] ramp [3];
  logic [FracW-1:0] v_next [3];

  always_comb begin
    span = lv_q - lv_p;
    for (int c = 0; c < 3; c++) begin
      if (lv_t[c] < HueSixth) w[c] = lv_t[c][8:0];
      else w[c] = 9'(HueTwoThirds - lv_t[c]);
      m[c] = {9'd0, span} * {16'd0, w[c]} + 25'd128;
      ramp[c] = lv_p + m[c][23:8];
      if (lv_t[c] < HueSixth) v_next[c] = ramp[c];
      else if (lv_t[c] < HueHalf) v_next[c] = lv_q;
      else if (lv_t[c] < HueTwoThirds) v_next[c] = ramp[c];
      else v_next[c] = lv_p;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ch_v     <= v_next;
      ch_alpha <= lv_alpha;
    end
  end

  // Byte stage: round each level to eight bits.
  logic [ChanW-1:0] b_next [3];
  logic [31:0]      bx     [3];
  logic [16:0]      bq     [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      bx[c] = {8'd0, ch_v[c], 8'd0} - {16'd0, ch_v[c]} + 32'd32767;
      bq[c] = div_65535(bx[c]);
      b_next[c] = bq[c][ChanW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      alpha_out <= ch_alpha;
      red_out   <= b_next[0];
      green_out <= b_next[1];
      blue_out  <= b_next[2];
    end
  end

endmodule

`default_nettype wire

// ===== bench/hsl_saturation_lightness_adjust_tb.sv =====
`default_nettype none

module hsl_saturation_lightness_adjust_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hsl_pkg::*;

  // Allow a generous margin when draining the pipeline.
  localparam int DrainCycles = 40;
  localparam int WatchdogLimit = 5000;

  typedef struct packed {
    logic [ChanW-1:0] alpha;
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } pixel_t;

  // One row of the directed table: the input pixel, the gains that apply to
  // it, and optionally a result that can be read off by eye.
  typedef struct packed {
    logic [GainW-1:0] sat_gain;
    logic [GainW-1:0] lum_gain;
    pixel_t           pix;
    logic             known;
    pixel_t           result;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [ChanW-1:0] alpha_in = '0;
  logic [ChanW-1:0] red_in = '0;
  logic [ChanW-1:0] green_in = '0;
  logic [ChanW-1:0] blue_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [ChanW-1:0] alpha_out;
  logic [ChanW-1:0] red_out;
  logic [ChanW-1:0] green_out;
  logic [ChanW-1:0] blue_out;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  hsl_saturation_lightness_adjust i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .alpha_in  (alpha_in),
    .red_in    (red_in),
    .green_in  (green_in),
    .blue_in   (blue_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .alpha_out (alpha_out),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // The bench's own copy of the gain registers, updated as they are written.
  logic [GainW-1:0] sat_gain_q = GainUnity;
  logic [GainW-1:0] lum_gain_q = GainUnity;

  pixel_t adjusted_pixels[$];
  int     fault_count = 0;
  int     idle_cycles = 0;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;

  task automatic report_fault(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fault_count++;
  endtask

  function automatic logic [63:0] round_div(input logic [63:0] n, input logic [63:0] d);
    return (n + d / 2) / d;
  endfunction

  function automatic logic [63:0] scale_by_gain(input logic [63:0] v,
                                                input logic [GainW-1:0] gain);
    logic [63:0] r;
    r = (v * gain + 128) >> 8;
    return (r > 65535) ? 64'd65535 : r;
  endfunction

  // Colour value at one position of the turn, between the low and high levels.
  function automatic logic [63:0] ramp_level(input logic [63:0] lo, input logic [63:0] hi,
                                             input logic [63:0] t);
    if (t < 256) return lo + (((hi - lo) * t + 128) >> 8);
    if (t < 768) return hi;
    if (t < 1024) return lo + (((hi - lo) * (1024 - t) + 128) >> 8);
    return lo;
  endfunction

  function automatic logic [ChanW-1:0] frac_to_byte(input longint v);
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return 8'(round_div(64'(v) * 255, 65535));
  endfunction

  // Half away from zero: round(num*256/d) with a sign.
  function automatic longint signed_hue_step(input longint num, input longint d);
    if (num < 0) return -longint'(round_div(64'(-num) * 256, 64'(d)));
    return longint'(round_div(64'(num) * 256, 64'(d)));
  endfunction

  function automatic pixel_t adjust_pixel(input pixel_t px, input logic [GainW-1:0] sg,
                                          input logic [GainW-1:0] lg);
    longint r, g, b, mx, mn, h, hi, lo;
    logic [63:0] d, sm, lum, sat, hue, den, prod;
    pixel_t res;
    r = px.red; g = px.green; b = px.blue;
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = 64'(mx - mn);
    sm = 64'(mx + mn);
    lum = (sm * 65535 + 255) / 510;
    sat = 0;
    hue = 0;
    if (d != 0) begin
      den = (sm < 255) ? sm : 510 - sm;
      sat = round_div(d * 65535, den);
      if (mx == r) begin
        h = signed_hue_step(g - b, longint'(d));
        if (h < 0) h += 1536;
      end else if (mx == g) begin
        h = 512 + signed_hue_step(b - r, longint'(d));
      end else begin
        h = 1024 + signed_hue_step(r - g, longint'(d));
      end
      hue = 64'(h);
    end
    sat = scale_by_gain(sat, sg);
    lum = scale_by_gain(lum, lg);
    res.alpha = px.alpha;
    if (sat == 0) begin
      res.red = frac_to_byte(longint'(lum));
      res.green = res.red;
      res.blue = res.red;
    end else begin
      prod = round_div(lum * sat, 65535);
      hi = (lum <= 32767) ? longint'(lum + prod) : longint'(lum + sat) - longint'(prod);
      lo = 2 * longint'(lum) - hi;
      if (hi > 65535) hi = 65535;
      if (lo < 0) lo = 0;
      if (lo > hi) lo = hi;
      res.red = frac_to_byte(longint'(ramp_level(64'(lo), 64'(hi), (hue + 512) % 1536)));
      res.green = frac_to_byte(longint'(ramp_level(64'(lo), 64'(hi), hue % 1536)));
      res.blue = frac_to_byte(longint'(ramp_level(64'(lo), 64'(hi), (hue + 1024) % 1536)));
    end
    return res;
  endfunction

  // Output side: compare every accepted transaction with the oldest expectation.
  always @(posedge clk) begin
    pixel_t want;
    if (!rst && out_valid && !out_stall) begin
      if (adjusted_pixels.size() == 0) begin
        $display("[%0t] result transaction with nothing expected", $realtime);
        fault_count++;
      end else begin
        want = adjusted_pixels.pop_front();
        if (alpha_out !== want.alpha) report_fault("alpha_out", alpha_out, want.alpha);
        if (red_out !== want.red) report_fault("red_out", red_out, want.red);
        if (green_out !== want.green) report_fault("green_out", green_out, want.green);
        if (blue_out !== want.blue) report_fault("blue_out", blue_out, want.blue);
      end
    end
  end

  // The receiver stalls at random, with the share set by the current phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog: cycles in a row in which neither channel completes a transaction.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic wait_drained();
    while (adjusted_pixels.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Write one gain register: a setup phase, then an access phase.
  task automatic write_gain(input logic reg_sel, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_sel, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (reg_sel == RegSatGain) sat_gain_q = value[GainW-1:0];
    else lum_gain_q = value[GainW-1:0];
  endtask

  task automatic set_gains(input logic [GainW-1:0] sg, input logic [GainW-1:0] lg);
    if (sg != sat_gain_q || lg != lum_gain_q) begin
      in_valid <= 1'b0;
      wait_drained();
      write_gain(RegSatGain, 32'(sg));
      write_gain(RegLumGain, 32'(lg));
    end
  endtask

  // Present one pixel and hold it until the block takes it; the expectation
  // is queued at the edge of acceptance.
  task automatic send_pixel(input pixel_t px, input pixel_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    alpha_in <= px.alpha;
    red_in <= px.red;
    green_in <= px.green;
    blue_in <= px.blue;
    do @(posedge clk); while (in_stall);
    adjusted_pixels.push_back(want);
  endtask

  function automatic pixel_t random_pixel();
    pixel_t px;
    logic [ChanW-1:0] base;
    px = pixel_t'($urandom);
    // Some near-grey pixels, so that small spreads between channels are frequent.
    if ($urandom_range(3) == 0) begin
      base = px.red;
      px.green = base + 8'($urandom_range(2));
      px.blue = base - 8'($urandom_range(2));
    end
    return px;
  endfunction

  function automatic logic [GainW-1:0] random_gain();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return GainUnity;
      default: return GainW'($urandom);
    endcase
  endfunction

  directed_row_t directed_rows[] = '{
    // Black, white and grey at unity gain, alpha at both extremes.
    '{GainUnity, GainUnity, 32'h00000000, 1'b1, 32'h00000000},
    '{GainUnity, GainUnity, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF},
    '{GainUnity, GainUnity, 32'h80808080, 1'b1, 32'h80808080},
    // Primaries and secondaries at unity gain come back unchanged.
    '{GainUnity, GainUnity, 32'hFFFF0000, 1'b1, 32'hFFFF0000},
    '{GainUnity, GainUnity, 32'h0000FF00, 1'b1, 32'h0000FF00},
    '{GainUnity, GainUnity, 32'h7F0000FF, 1'b1, 32'h7F0000FF},
    '{GainUnity, GainUnity, 32'h01FFFF00, 1'b1, 32'h01FFFF00},
    '{GainUnity, GainUnity, 32'hFE00FFFF, 1'b1, 32'hFE00FFFF},
    '{GainUnity, GainUnity, 32'h55FF00FF, 1'b1, 32'h55FF00FF},
    // Hue just past magenta, and mixed colours.
    '{GainUnity, GainUnity, 32'hAAFF00FE, 1'b0, 32'h0},
    '{GainUnity, GainUnity, 32'h12345678, 1'b0, 32'h0},
    '{GainUnity, GainUnity, 32'hC0C8641E, 1'b0, 32'h0},
    // Near-grey pixel: a spread of one.
    '{GainUnity, GainUnity, 32'h33646465, 1'b0, 32'h0},
    // Zero saturation gain turns everything grey.
    '{12'd0, GainUnity, 32'h00FF0000, 1'b1, 32'h00808080},
    '{12'd0, GainUnity, 32'h4C1080F0, 1'b0, 32'h0},
    // Zero lightness gain gives black.
    '{GainUnity, 12'd0, 32'h99FF8000, 1'b1, 32'h99000000},
    '{12'd0, 12'd0, 32'hFFFFFFFF, 1'b1, 32'hFF000000},
    // Largest lightness gain saturates to white.
    '{GainUnity, 12'hFFF, 32'h66204060, 1'b1, 32'h66FFFFFF},
    // Largest saturation gain.
    '{12'hFFF, GainUnity, 32'h70806070, 1'b0, 32'h0},
    '{12'hFFF, GainUnity, 32'h00A0A0A1, 1'b0, 32'h0},
    '{12'hFFF, 12'hFFF, 32'hFF102030, 1'b0, 32'h0},
    // Gains just around one, then one and a half and one half.
    '{12'd255, 12'd257, 32'h80C04020, 1'b0, 32'h0},
    '{12'd384, 12'd128, 32'h80FFFFFE, 1'b0, 32'h0}
  };

  initial begin
    pixel_t px;
    pixel_t want;
    int phase_items;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // A register read returns the reset value of the saturation gain and pready is high; checked once after reset.
    if (pready !== 1'b1) report_fault("pready", pready, 1);
    if (prdata !== 32'(GainUnity)) report_fault("prdata", prdata, GainUnity);

    foreach (directed_rows[i]) begin
      set_gains(directed_rows[i].sat_gain, directed_rows[i].lum_gain);
      px = directed_rows[i].pix;
      want = adjust_pixel(px, sat_gain_q, lum_gain_q);
      if (directed_rows[i].known && want != directed_rows[i].result)
        report_fault("table entry", int'(want), int'(directed_rows[i].result));
      send_pixel(px, directed_rows[i].known ? directed_rows[i].result : want);
    end
    in_valid <= 1'b0;

    // Three phases of random traffic; the gains change every so often,
    // always with the pipeline empty.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 22 : (phase == 1) ? 82 : 0;
      recv_stall_pct = (phase == 0) ? 82 : (phase == 1) ? 22 : 0;
      phase_items = 0;
      while (phase_items < 400) begin
        if (phase_items % 100 == 0) begin
          in_valid <= 1'b0;
          // If the gains change, the sender holds back until every result has arrived.
          set_gains(random_gain(), random_gain());
        end
        px = random_pixel();
        send_pixel(px, adjust_pixel(px, sat_gain_q, lum_gain_q));
        phase_items++;
      end
      in_valid <= 1'b0;
    end

    wait_drained();
    if (fault_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
src/hsl_pkg.sv
src/hsl_analyse.sv
src/hsl_div.sv
src/hsl_delay.sv
src/hsl_synth.sv
src/hsl_saturation_lightness_adjust.sv
bench/hsl_saturation_lightness_adjust_tb.sv
